// ===== design/fyp_pkg.sv =====
// Shared constants, select codes and control structs for the permutation core.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package fyp_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = SLOT_W + 1;
   localparam int WORD_W      = 31;
   localparam int DIV_CNT_W   = $clog2(WORD_W + 1);

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CURSOR,
      RD_REM,
      RD_ZERO
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_FILL,
      WR_CURSOR,
      WR_REM
   } wr_sel_type;

   typedef enum logic [1:0] {
      RSP_MAIN,
      RSP_SINGLE,
      RSP_FINAL
   } rsp_kind_type;

   typedef struct packed {
      logic         load_word;
      logic         start_round;
      logic         fill_step;
      logic         div_start;
      rd_sel_type   rd_sel;
      logic         latch_vi;
      logic         latch_vr;
      wr_sel_type   wr_sel;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
      logic         cursor_dec;
      logic         cursor_clear;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic fill_last;
      logic div_busy;
      logic cursor_low;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== design/fyp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fyp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/fyp_divider.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Depends on fyp_pkg for widths.
`default_nettype none

module fyp_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [fyp_pkg::WORD_W-1:0]    dividend,
   input  wire logic [fyp_pkg::COUNT_W-1:0]   divisor,
   output logic                               busy,
   output logic      [fyp_pkg::SLOT_W-1:0]    remainder
);

   logic                            busy_ff;
   logic [fyp_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [fyp_pkg::WORD_W-1:0]      quot_ff;
   logic [fyp_pkg::SLOT_W-1:0]      rem_ff;
   logic [fyp_pkg::SLOT_W-1:0]      rem_in;
   logic [fyp_pkg::COUNT_W-1:0]     divisor_ff;
   logic [fyp_pkg::COUNT_W-1:0]     shifted;

   always_comb begin
      shifted = {rem_ff, quot_ff[fyp_pkg::WORD_W-1]};
      if (shifted >= divisor_ff) begin
         rem_in = fyp_pkg::SLOT_W'(shifted - divisor_ff);
      end else begin
         rem_in = shifted[fyp_pkg::SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= fyp_pkg::DIV_CNT_W'(fyp_pkg::WORD_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - fyp_pkg::DIV_CNT_W'(1);
         if (cnt_ff == fyp_pkg::DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[fyp_pkg::WORD_W-2:0], 1'b0};
         rem_ff  <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/fyp_datapath.sv =====
// Datapath: count register, cursor, identity fill, swap through the table RAM,
// remainder unit and the result register. Depends on fyp_pkg, fyp_ram, fyp_divider.
`default_nettype none

module fyp_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fyp_pkg::COUNT_W-1:0]   csr_entry_count,
   input  wire logic [fyp_pkg::WORD_W-1:0]    req_random_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [fyp_pkg::SLOT_W-1:0]    rsp_position,
   output logic      [fyp_pkg::SLOT_W-1:0]    rsp_value,
   output logic                               rsp_round_end,
   input  wire fyp_pkg::cmd_type              cmd,
   output fyp_pkg::status_type                status
);

   logic [fyp_pkg::COUNT_W-1:0] count_ff;
   logic [fyp_pkg::COUNT_W-1:0] n_sat;
   logic [fyp_pkg::COUNT_W-1:0] n_less;
   logic [fyp_pkg::WORD_W-1:0]  word_ff;
   logic [fyp_pkg::SLOT_W-1:0]  cursor_ff;
   logic [fyp_pkg::SLOT_W-1:0]  fill_idx_ff;
   logic [fyp_pkg::SLOT_W-1:0]  vi_ff;
   logic [fyp_pkg::SLOT_W-1:0]  vr_ff;
   logic [fyp_pkg::SLOT_W-1:0]  rem;
   logic                        div_busy;
   logic                        rd_en;
   logic [fyp_pkg::SLOT_W-1:0]  rd_addr;
   logic [fyp_pkg::SLOT_W-1:0]  rd_data;
   logic                        wr_en;
   logic [fyp_pkg::SLOT_W-1:0]  wr_addr;
   logic [fyp_pkg::SLOT_W-1:0]  wr_data;
   logic                        rsp_valid_ff;
   logic [fyp_pkg::SLOT_W-1:0]  rsp_position_ff;
   logic [fyp_pkg::SLOT_W-1:0]  rsp_value_ff;
   logic                        rsp_round_end_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_entry_count;
      end
   end

   assign n_sat  = (count_ff > fyp_pkg::COUNT_W'(fyp_pkg::MAX_ENTRIES))
                   ? fyp_pkg::COUNT_W'(fyp_pkg::MAX_ENTRIES) : count_ff;
   assign n_less = n_sat - fyp_pkg::COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else if (cmd.start_round) begin
         cursor_ff <= n_less[fyp_pkg::SLOT_W-1:0];
      end else if (cmd.cursor_clear) begin
         cursor_ff <= '0;
      end else if (cmd.cursor_dec) begin
         cursor_ff <= cursor_ff - fyp_pkg::SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         word_ff <= req_random_word;
      end
      if (cmd.start_round) begin
         fill_idx_ff <= '0;
      end else if (cmd.fill_step) begin
         fill_idx_ff <= fill_idx_ff + fyp_pkg::SLOT_W'(1);
      end
      if (cmd.latch_vi) begin
         vi_ff <= rd_data;
      end
      if (cmd.latch_vr) begin
         vr_ff <= rd_data;
      end
   end

   fyp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (word_ff),
      .divisor   (fyp_pkg::COUNT_W'(cursor_ff) + fyp_pkg::COUNT_W'(1)),
      .busy      (div_busy),
      .remainder (rem)
   );

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      case (cmd.rd_sel)
         fyp_pkg::RD_CURSOR: rd_addr = cursor_ff;
         fyp_pkg::RD_REM:    rd_addr = rem;
         fyp_pkg::RD_ZERO:   rd_addr = '0;
         default:            rd_en   = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
      case (cmd.wr_sel)
         fyp_pkg::WR_FILL: begin
            wr_addr = fill_idx_ff;
            wr_data = fill_idx_ff;
         end
         fyp_pkg::WR_CURSOR: begin
            wr_addr = cursor_ff;
            wr_data = rd_data;
         end
         fyp_pkg::WR_REM: begin
            wr_addr = rem;
            wr_data = vi_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   fyp_ram #(
      .WIDTH (fyp_pkg::SLOT_W),
      .DEPTH (fyp_pkg::MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.rsp_kind)
            fyp_pkg::RSP_MAIN: begin
               rsp_position_ff  <= cursor_ff;
               rsp_value_ff     <= vr_ff;
               rsp_round_end_ff <= 1'b0;
            end
            fyp_pkg::RSP_FINAL: begin
               rsp_position_ff  <= '0;
               rsp_value_ff     <= rd_data;
               rsp_round_end_ff <= 1'b1;
            end
            default: begin
               rsp_position_ff  <= '0;
               rsp_value_ff     <= '0;
               rsp_round_end_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_round_end = rsp_round_end_ff;

   assign status.n_zero     = (n_sat == '0);
   assign status.n_one      = (n_sat == fyp_pkg::COUNT_W'(1));
   assign status.fill_last  = (fill_idx_ff == cursor_ff);
   assign status.div_busy   = div_busy;
   assign status.cursor_low = (cursor_ff <= fyp_pkg::SLOT_W'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// ===== design/fyp_controller.sv =====
// Controller state machine: sequences round start, identity fill, remainder,
// swap and result emission. Depends on fyp_pkg.
`default_nettype none

module fyp_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire fyp_pkg::status_type  status,
   output fyp_pkg::cmd_type          cmd
);

   typedef enum logic [3:0] {
      IDLE,
      EMIT_SINGLE,
      FILL,
      DIV_START,
      DIV_WAIT,
      READ_I,
      READ_R,
      WRITE_I,
      WRITE_R,
      EMIT_MAIN,
      READ_ZERO,
      EMIT_FINAL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      active_ff;
   logic      active_in;

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      cmd       = '0;
      cmd.rd_sel   = fyp_pkg::RD_NONE;
      cmd.wr_sel   = fyp_pkg::WR_NONE;
      cmd.rsp_kind = fyp_pkg::RSP_MAIN;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_word = 1'b1;
               if (active_ff) begin
                  state_in = DIV_START;
               end else if (status.n_zero) begin
                  state_in = IDLE;
               end else if (status.n_one) begin
                  state_in = EMIT_SINGLE;
               end else begin
                  cmd.start_round = 1'b1;
                  active_in       = 1'b1;
                  state_in        = FILL;
               end
            end
         end
         EMIT_SINGLE: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = fyp_pkg::RSP_SINGLE;
               state_in     = IDLE;
            end
         end
         FILL: begin
            cmd.fill_step = 1'b1;
            cmd.wr_sel    = fyp_pkg::WR_FILL;
            if (status.fill_last) begin
               state_in = DIV_START;
            end
         end
         DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = DIV_WAIT;
         end
         DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = READ_I;
            end
         end
         READ_I: begin
            cmd.rd_sel = fyp_pkg::RD_CURSOR;
            state_in   = READ_R;
         end
         READ_R: begin
            cmd.rd_sel   = fyp_pkg::RD_REM;
            cmd.latch_vi = 1'b1;
            state_in     = WRITE_I;
         end
         WRITE_I: begin
            cmd.wr_sel   = fyp_pkg::WR_CURSOR;
            cmd.latch_vr = 1'b1;
            state_in     = WRITE_R;
         end
         WRITE_R: begin
            cmd.wr_sel = fyp_pkg::WR_REM;
            state_in   = EMIT_MAIN;
         end
         EMIT_MAIN: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = fyp_pkg::RSP_MAIN;
               if (status.cursor_low) begin
                  state_in = READ_ZERO;
               end else begin
                  cmd.cursor_dec = 1'b1;
                  state_in       = IDLE;
               end
            end
         end
         READ_ZERO: begin
            cmd.rd_sel = fyp_pkg::RD_ZERO;
            state_in   = EMIT_FINAL;
         end
         EMIT_FINAL: begin
            if (status.out_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_kind     = fyp_pkg::RSP_FINAL;
               cmd.cursor_clear = 1'b1;
               active_in        = 1'b0;
               state_in         = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/fisher_yates_permutation_core.sv =====
// Top level of the Fisher-Yates permutation core: controller plus datapath.
// Depends on fyp_pkg, fyp_controller, fyp_datapath.
//
// Each accepted random word performs one swap of the shuffle and returns the
// slot fixed by it; the last swap of a round also returns slot 0 with
// round_end set. An item runs the one-bit-per-cycle remainder unit, then the
// table reads and writes of the swap and the load of the result register; the
// item that closes a round then also reads slot 0. The item that opens a round
// first writes the identity into the N used table entries, one entry per cycle.
// The entry count is sampled when a round opens; counts above 1024 act as 1024.
// A count of one returns slot 0 with round_end set; a count of zero returns nothing.
`default_nettype none

module fisher_yates_permutation_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fyp_pkg::COUNT_W-1:0]   csr_entry_count,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [fyp_pkg::WORD_W-1:0]    req_random_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [fyp_pkg::SLOT_W-1:0]    rsp_position,
   output logic      [fyp_pkg::SLOT_W-1:0]    rsp_value,
   output logic                               rsp_round_end
);

   fyp_pkg::cmd_type    cmd;
   fyp_pkg::status_type status;

   fyp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fyp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_count (csr_entry_count),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_value       (rsp_value),
      .rsp_round_end   (rsp_round_end),
      .cmd             (cmd),
      .status          (status)
   );

`ifndef SYNTHESIS
   a_end_at_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_round_end |-> rsp_position == '0)
      else $error("round end item not at slot zero");

   a_no_write_while_div: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> cmd.wr_sel == fyp_pkg::WR_NONE && !req_ready)
      else $error("table write or new item while remainder busy");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.out_free)
      else $error("result register overwritten");

   a_div_result_held: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_sel == fyp_pkg::WR_REM |-> $past(cmd.rd_sel) == fyp_pkg::RD_CURSOR ||
      $past(cmd.wr_sel) == fyp_pkg::WR_CURSOR)
      else $error("swap sequence out of order");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for fisher_yates_permutation_core: streams random words, predicts the
// fixed slots of each shuffle round in-bench and checks every returned result.
// Depends on fyp_pkg and the core RTL.

module tb_top;

   localparam int HOLD_CYCLES   = 500;
   localparam int SETTLE_CYCLES = 1200;
   localparam int MAX_REPORTS   = 10;
   localparam int TARGET_WORDS  = 1950;

   typedef struct packed {
      logic [fyp_pkg::SLOT_W-1:0] position;
      logic [fyp_pkg::SLOT_W-1:0] value;
      logic                       round_end;
   } slot_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [fyp_pkg::COUNT_W-1:0] csr_entry_count = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [fyp_pkg::WORD_W-1:0]  req_random_word = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [fyp_pkg::SLOT_W-1:0]  rsp_position;
   logic [fyp_pkg::SLOT_W-1:0]  rsp_value;
   logic                        rsp_round_end;

   logic [fyp_pkg::WORD_W-1:0]  pending_words[$];
   slot_result_type             expected_slots[$];
   slot_result_type             head_slot;
   int unsigned                 words_issued = 0;
   int unsigned                 words_taken = 0;
   int unsigned                 mismatch_count = 0;
   int unsigned                 hold_left = 0;
   bit                          hold_done = 1'b0;

   logic [fyp_pkg::SLOT_W-1:0]  slot_table [fyp_pkg::MAX_ENTRIES];
   bit                          slot_written [fyp_pkg::MAX_ENTRIES];
   int unsigned                 shuffle_cursor = 0;
   bit                          round_open = 1'b0;
   logic [fyp_pkg::COUNT_W-1:0] entry_count_q = '0;

   fisher_yates_permutation_core uut (.*);

   always #10 clock = ~clock;

   function automatic void add_word(logic [fyp_pkg::WORD_W-1:0] w);
      pending_words = {pending_words, w};
   endfunction

   function automatic logic [fyp_pkg::SLOT_W-1:0] slot_read(int unsigned idx);
      return slot_written[idx] ? slot_table[idx] : fyp_pkg::SLOT_W'(idx);
   endfunction

   function automatic void expect_slot(int unsigned pos, logic [fyp_pkg::SLOT_W-1:0] val,
                                       logic last);
      slot_result_type s;
      s.position  = fyp_pkg::SLOT_W'(pos);
      s.value     = val;
      s.round_end = last;
      expected_slots = {expected_slots, s};
   endfunction

   function automatic void shuffle_step(logic [fyp_pkg::WORD_W-1:0] word);
      int unsigned n;
      int unsigned i;
      int unsigned r;
      logic [fyp_pkg::SLOT_W-1:0] vi;
      logic [fyp_pkg::SLOT_W-1:0] vr;
      if (!round_open) begin
         n = (entry_count_q > fyp_pkg::MAX_ENTRIES) ? fyp_pkg::MAX_ENTRIES : entry_count_q;
         if (n == 0)
            return;
         if (n == 1) begin
            expect_slot(0, '0, 1'b1);
            return;
         end
         foreach (slot_written[k])
            slot_written[k] = 1'b0;
         shuffle_cursor = n - 1;
         round_open = 1'b1;
      end
      i  = shuffle_cursor;
      r  = word % (i + 1);
      vi = slot_read(i);
      vr = slot_read(r);
      slot_table[i]   = vr;
      slot_written[i] = 1'b1;
      slot_table[r]   = vi;
      slot_written[r] = 1'b1;
      expect_slot(i, vr, 1'b0);
      if (i <= 1) begin
         expect_slot(0, slot_read(0), 1'b1);
         round_open = 1'b0;
         shuffle_cursor = 0;
      end else begin
         shuffle_cursor = i - 1;
      end
   endfunction

   function automatic logic [fyp_pkg::WORD_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2, 3:    return fyp_pkg::WORD_W'($urandom_range(0, 4095));
         default: return fyp_pkg::WORD_W'($urandom());
      endcase
   endfunction

   task automatic drain_and_settle();
      while (pending_words.size() != 0 || words_taken != words_issued ||
             expected_slots.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_entry_count(logic [fyp_pkg::COUNT_W-1:0] count);
      drain_and_settle();
      @(negedge clock);
      csr_entry_count <= count;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sample handshakes, advance the shuffle, check results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            entry_count_q = csr_entry_count;
         if (req_valid && req_ready) begin
            shuffle_step(req_random_word);
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_slots.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result: position %0d value %0d round_end %0b",
                           rsp_position, rsp_value, rsp_round_end);
            end else begin
               head_slot = expected_slots.pop_front();
               if (head_slot.position !== rsp_position || head_slot.value !== rsp_value ||
                   head_slot.round_end !== rsp_round_end) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("mismatch: exp pos %0d val %0d end %0b, got pos %0d val %0d end %0b",
                              head_slot.position, head_slot.value, head_slot.round_end,
                              rsp_position, rsp_value, rsp_round_end);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && words_taken < words_issued) begin
         // hold until taken
      end else if (pending_words.size() != 0 && $urandom_range(0, 99) >=
                   (words_taken < 650 ? 38 : words_taken < 1300 ? 77 : 0)) begin
         req_random_word <= pending_words.pop_front();
         req_valid <= 1'b1;
         words_issued++;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_taken >= 1400 && req_valid) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >=
                      (words_taken < 650 ? 77 : words_taken < 1300 ? 38 : 0);
      end
   end

   initial begin
      int unsigned total;
      int unsigned n_items;
      logic [fyp_pkg::COUNT_W-1:0] count;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_entry_count('0);
      add_word('0);
      add_word('1);
      set_entry_count(fyp_pkg::COUNT_W'(1));
      add_word('1);
      add_word('0);
      set_entry_count(fyp_pkg::COUNT_W'(2));
      add_word('0);
      add_word('1);
      set_entry_count(fyp_pkg::COUNT_W'(5));
      add_word('1);
      add_word('0);
      add_word(fyp_pkg::WORD_W'(32'h5555_5555));
      add_word(fyp_pkg::WORD_W'(32'h2AAA_AAAA));
      add_word(fyp_pkg::WORD_W'(4));
      add_word(fyp_pkg::WORD_W'(1));
      // change count while a round is open
      set_entry_count(fyp_pkg::COUNT_W'(3));
      add_word(fyp_pkg::WORD_W'(2));
      add_word('1);
      add_word(fyp_pkg::WORD_W'(7));
      add_word('0);
      total = 16;

      // full-size round, count above the table size
      set_entry_count('1);
      repeat (300) add_word(random_word());
      set_entry_count('0);
      repeat (fyp_pkg::MAX_ENTRIES - 1 - 300) add_word(random_word());
      total += fyp_pkg::MAX_ENTRIES - 1;

      while (total < TARGET_WORDS) begin
         case ($urandom_range(0, 9))
            0:       count = fyp_pkg::COUNT_W'($urandom_range(0, 1));
            1:       count = fyp_pkg::COUNT_W'($urandom_range(41, 300));
            default: count = fyp_pkg::COUNT_W'($urandom_range(2, 40));
         endcase
         n_items = (count == 0) ? 3 : $urandom_range(10, 60);
         set_entry_count(count);
         repeat (n_items) add_word(random_word());
         if (count != 0)
            total += n_items;
      end

      drain_and_settle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
